@@ hdl/bis_pkg.sv @@
package bis_pkg;

  localparam int MAX_ELEMS_DEF  = 1024;
  localparam int MAX_BLOCKS_DEF = 1024;

  localparam int REG_W     = 11;
  localparam int KEY_W     = 32;
  localparam int POS_W     = 10;
  localparam int STATUS_W  = 3;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [REG_W-1:0] ELEM_COUNT_RST = 11'd1024;
  localparam logic [REG_W-1:0] BLOCK_SIZE_RST = 11'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd1;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED = 3'd0,
    ST_REJECT = 3'd1,
    ST_FOUND  = 3'd2,
    ST_MISS   = 3'd3,
    ST_CLEAR  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BS,
    S_BW,
    S_SETUP,
    S_CALC,
    S_SCAN
  } state_t;

endpackage

@@ hdl/block_indexed_search.sv @@
// Indexed block search over a sorted table held in on-chip memory.
// Input channel: drive in_req_type and in_key with start high; the item is
// taken at the clock edge where start is high and busy is low. A load appends
// in_key if not full, a query searches for in_key, a clear restarts loading.
// Result channel: out_status and out_position are shown for exactly one cycle
// with out_valid high; the receiver cannot stall and must take it then.
// Configuration: cfg_index/cfg_data written when cfg_valid and cfg_ready are
// high; cfg_ready is always high. Index 0 is elem_count, index 1 block_size.
// Loads and clears: each gives its result in the cycle after it is taken
// and busy stays low, so one of these can be taken every cycle.
// A query holds busy until its result: a binary search over the index entries
// picks one block, then at most block_size positions of it are scanned. The
// binary search costs one index-memory read and one compare per step, the scan
// reads one value-memory entry per cycle, pipelined.
// Reset (synchronous, rst_n low) empties the table and restores elem_count
// to 1024 and block_size to 32; memory contents are not cleared.
module block_indexed_search #(
  parameter int MAX_ELEMS  = bis_pkg::MAX_ELEMS_DEF,
  parameter int MAX_BLOCKS = bis_pkg::MAX_BLOCKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [bis_pkg::REQ_W-1:0]        in_req_type,
  input  logic signed [bis_pkg::KEY_W-1:0] in_key,
  output logic                             out_valid,
  output logic [bis_pkg::STATUS_W-1:0]     out_status,
  output logic [bis_pkg::POS_W-1:0]        out_position,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bis_pkg::REG_W-1:0]        cfg_data
);
  import bis_pkg::*;

  localparam int EW = $clog2(MAX_ELEMS + 1);
  localparam int EA = $clog2(MAX_ELEMS);
  localparam int BA = $clog2(MAX_BLOCKS);

  logic [REG_W-1:0] elem_count_r, elem_count_nxt;
  logic [REG_W-1:0] block_size_r, block_size_nxt;
  logic [31:0] ec_ext, bs_ext;
  logic [EW-1:0] n_eff, b_eff;

  logic val_we, val_re, idx_we, idx_re;
  logic [EA-1:0] val_waddr, val_raddr;
  logic [BA-1:0] idx_waddr, idx_raddr;
  logic [KEY_W-1:0] val_wdata, val_rdata, idx_wdata, idx_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    elem_count_nxt = elem_count_r;
    block_size_nxt = block_size_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ELEM_COUNT) elem_count_nxt = cfg_data;
      else if (cfg_index == CFG_BLOCK_SIZE) block_size_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_count_r <= ELEM_COUNT_RST;
      block_size_r <= BLOCK_SIZE_RST;
    end else begin
      elem_count_r <= elem_count_nxt;
      block_size_r <= block_size_nxt;
    end
  end

  // clamp to table size; a zero block size acts as one
  assign ec_ext = 32'(elem_count_r);
  assign bs_ext = (block_size_r == '0) ? 32'd1 : 32'(block_size_r);
  assign n_eff = (ec_ext > 32'(MAX_ELEMS)) ? EW'(MAX_ELEMS) : EW'(ec_ext);
  assign b_eff = (bs_ext > 32'(MAX_ELEMS)) ? EW'(MAX_ELEMS) : EW'(bs_ext);

  bis_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAX_ELEMS)
  ) u_value_ram (
    .clk  (clk),
    .we   (val_we),
    .waddr(val_waddr),
    .wdata(val_wdata),
    .re   (val_re),
    .raddr(val_raddr),
    .rdata(val_rdata)
  );

  bis_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAX_BLOCKS)
  ) u_index_ram (
    .clk  (clk),
    .we   (idx_we),
    .waddr(idx_waddr),
    .wdata(idx_wdata),
    .re   (idx_re),
    .raddr(idx_raddr),
    .rdata(idx_rdata)
  );

  bis_ctrl #(
    .MAX_ELEMS (MAX_ELEMS),
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_key      (in_key),
    .n_eff       (n_eff),
    .b_eff       (b_eff),
    .val_we      (val_we),
    .val_waddr   (val_waddr),
    .val_wdata   (val_wdata),
    .val_re      (val_re),
    .val_raddr   (val_raddr),
    .val_rdata   (val_rdata),
    .idx_we      (idx_we),
    .idx_waddr   (idx_waddr),
    .idx_wdata   (idx_wdata),
    .idx_re      (idx_re),
    .idx_raddr   (idx_raddr),
    .idx_rdata   (idx_rdata),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_position(out_position)
  );

endmodule

@@ hdl/bis_ram.sv @@
module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/bis_ctrl.sv @@
module bis_ctrl #(
  parameter int MAX_ELEMS  = bis_pkg::MAX_ELEMS_DEF,
  parameter int MAX_BLOCKS = bis_pkg::MAX_BLOCKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [bis_pkg::REQ_W-1:0]           in_req_type,
  input  logic signed [bis_pkg::KEY_W-1:0]    in_key,
  input  logic [$clog2(MAX_ELEMS+1)-1:0]      n_eff,
  input  logic [$clog2(MAX_ELEMS+1)-1:0]      b_eff,
  output logic                                val_we,
  output logic [$clog2(MAX_ELEMS)-1:0]        val_waddr,
  output logic [bis_pkg::KEY_W-1:0]           val_wdata,
  output logic                                val_re,
  output logic [$clog2(MAX_ELEMS)-1:0]        val_raddr,
  input  logic [bis_pkg::KEY_W-1:0]           val_rdata,
  output logic                                idx_we,
  output logic [$clog2(MAX_BLOCKS)-1:0]       idx_waddr,
  output logic [bis_pkg::KEY_W-1:0]           idx_wdata,
  output logic                                idx_re,
  output logic [$clog2(MAX_BLOCKS)-1:0]       idx_raddr,
  input  logic [bis_pkg::KEY_W-1:0]           idx_rdata,
  output logic                                out_valid,
  output logic [bis_pkg::STATUS_W-1:0]        out_status,
  output logic [bis_pkg::POS_W-1:0]           out_position
);
  import bis_pkg::*;

  localparam int EW = $clog2(MAX_ELEMS + 1);
  localparam int EA = $clog2(MAX_ELEMS);
  localparam int BA = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(((MAX_ELEMS > MAX_BLOCKS) ? MAX_ELEMS : MAX_BLOCKS) + 1);
  localparam int SW = CW + EW;

  state_t state_r, state_nxt;

  logic [EW-1:0] wc_r, wc_nxt;
  logic [EW-1:0] ibc_r, ibc_nxt;
  logic [EW-1:0] bt_r, bt_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [SW-1:0] start_r, start_nxt;
  logic [EW-1:0] issue_r, issue_nxt;
  logic [EW-1:0] end_r, end_nxt;
  logic [EW-1:0] pend_idx_r, pend_idx_nxt;
  logic pend_v_r, pend_v_nxt;
  logic out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;

  logic [EW-1:0] wc_inc, ibc_inc;
  logic [CW-1:0] cnt_c, mid_c;
  logic [SW:0] end_sum;
  logic [EW-1:0] end_lim, end_c;
  logic lo_lt_hi, lo_lt_cnt, start_lt_end, scan_hit, issue_lt_end, idx_room;
  logic is_load, is_query, wc_full;

  assign wc_inc  = wc_r + 1'b1;
  assign ibc_inc = ibc_r + 1'b1;
  assign idx_room = (CW'(bt_r) < CW'(MAX_BLOCKS));
  assign cnt_c   = idx_room ? CW'(bt_r) : CW'(MAX_BLOCKS);
  assign mid_c   = lo_r + ((hi_r - lo_r) >> 1);
  assign lo_lt_hi  = (lo_r < hi_r);
  assign lo_lt_cnt = (lo_r < cnt_r);
  assign end_sum = (SW+1)'(start_r) + (SW+1)'(b_eff);
  assign end_lim = (n_eff < wc_r) ? n_eff : wc_r;
  assign end_c   = (end_sum < (SW+1)'(end_lim)) ? EW'(end_sum) : end_lim;
  assign start_lt_end = ((SW+1)'(start_r) < (SW+1)'(end_c));
  assign scan_hit     = pend_v_r && (val_rdata == key_r);
  assign issue_lt_end = (issue_r < end_r);
  assign is_load  = (in_req_type == REQ_LOAD);
  assign is_query = (in_req_type == REQ_QUERY);
  assign wc_full  = (wc_r >= n_eff);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start && is_query) state_nxt = S_BS;
      end
      S_BS:    state_nxt = lo_lt_hi ? S_BW : S_SETUP;
      S_BW:    state_nxt = S_BS;
      S_SETUP: state_nxt = lo_lt_cnt ? S_CALC : S_IDLE;
      S_CALC:  state_nxt = start_lt_end ? S_SCAN : S_IDLE;
      S_SCAN: begin
        if (scan_hit || !issue_lt_end) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    wc_nxt = wc_r;
    ibc_nxt = ibc_r;
    bt_nxt = bt_r;
    key_nxt = key_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    cnt_nxt = cnt_r;
    mid_nxt = mid_r;
    start_nxt = start_r;
    issue_nxt = issue_r;
    end_nxt = end_r;
    pend_idx_nxt = pend_idx_r;
    pend_v_nxt = pend_v_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_pos_nxt = out_pos_r;
    val_we = 1'b0;
    val_waddr = EA'(wc_r);
    val_wdata = in_key;
    val_re = 1'b0;
    val_raddr = EA'(issue_r);
    idx_we = 1'b0;
    idx_waddr = BA'(bt_r);
    idx_wdata = in_key;
    idx_re = 1'b0;
    idx_raddr = BA'(mid_c);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (is_load) begin
            out_valid_nxt = 1'b1;
            out_pos_nxt = '0;
            if (wc_full) begin
              out_status_nxt = ST_REJECT;
            end else begin
              out_status_nxt = ST_LOADED;
              val_we = 1'b1;
              wc_nxt = wc_inc;
              ibc_nxt = ibc_inc;
              // close the block on a full block or on the last value
              if (ibc_inc >= b_eff || wc_inc == n_eff) begin
                idx_we = idx_room;
                bt_nxt = bt_r + 1'b1;
                ibc_nxt = '0;
              end
            end
          end else if (is_query) begin
            key_nxt = in_key;
            lo_nxt = '0;
            hi_nxt = cnt_c;
            cnt_nxt = cnt_c;
          end else begin
            wc_nxt = '0;
            ibc_nxt = '0;
            bt_nxt = '0;
            out_valid_nxt = 1'b1;
            out_status_nxt = ST_CLEAR;
            out_pos_nxt = '0;
          end
        end
      end
      S_BS: begin
        if (lo_lt_hi) begin
          idx_re = 1'b1;
          mid_nxt = mid_c;
        end
      end
      S_BW: begin
        if ($signed(idx_rdata) >= key_r) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + 1'b1;
        end
      end
      S_SETUP: begin
        start_nxt = SW'(lo_r) * SW'(b_eff);
        if (!lo_lt_cnt) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = ST_MISS;
          out_pos_nxt = '0;
        end
      end
      S_CALC: begin
        issue_nxt = EW'(start_r);
        end_nxt = end_c;
        pend_v_nxt = 1'b0;
        if (!start_lt_end) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = ST_MISS;
          out_pos_nxt = '0;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = ST_FOUND;
          out_pos_nxt = POS_W'(pend_idx_r);
          pend_v_nxt = 1'b0;
        end else if (issue_lt_end) begin
          // issue one read a cycle, compare it the cycle after
          val_re = 1'b1;
          pend_v_nxt = 1'b1;
          pend_idx_nxt = issue_r;
          issue_nxt = issue_r + 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
          out_status_nxt = ST_MISS;
          out_pos_nxt = '0;
          pend_v_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wc_r <= '0;
      ibc_r <= '0;
      bt_r <= '0;
      pend_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wc_r <= wc_nxt;
      ibc_r <= ibc_nxt;
      bt_r <= bt_nxt;
      pend_v_r <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    cnt_r <= cnt_nxt;
    mid_r <= mid_nxt;
    start_r <= start_nxt;
    issue_r <= issue_nxt;
    end_r <= end_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r <= out_pos_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_position = out_pos_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while a query is still running");

  a_blocks_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    bt_r <= wc_r)
    else $error("block count exceeds loaded value count");

  a_fill_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    ibc_r <= wc_r)
    else $error("in-block count exceeds loaded value count");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && is_query) |=> (busy && !out_valid_r))
    else $error("query did not enter search");

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !is_query) |=> (out_valid_r && !busy))
    else $error("load or clear gave no result in the next cycle");

endmodule
